[sv/fts_pkg.sv]
// Shared constants, types and helpers of the framed two-bit symbol sender.
package fts_pkg;

  // Bytes collected per frame; range 1 to 16.
  localparam int unsigned CHUNK_BYTES = 16;
  localparam int unsigned FILL_W      = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned IDX_W       = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

  localparam int unsigned SYM_W  = 3;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned SUM_W  = 8;

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_RESP = 2'd1,
    CMD_END  = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LAST   = 3'd0,
    KIND_START  = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_CSMARK = 3'd3,
    KIND_CS     = 3'd4,
    KIND_END    = 3'd5
  } kind_e;

  localparam logic [SYM_W-1:0] SYM_MARK_LAST  = 3'd1;
  localparam logic [SYM_W-1:0] SYM_MARK_START = 3'd1;
  localparam logic [SYM_W-1:0] SYM_MARK_CS    = 3'd2;
  localparam logic [SYM_W-1:0] SYM_MARK_END   = 3'd3;
  localparam logic [CNT_W-1:0] CNT_MARK       = 3'd1;
  localparam logic [CNT_W-1:0] CNT_GROUPS     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  store;     // write the byte, bump fill count and checksum
    logic  clear;     // empty the chunk
    logic  idx_inc;   // step to the next stored byte
    logic  idx_clr;   // rewind the byte index
    logic  emit;      // load the result register
    kind_e kind;
    logic  run_end;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_full;   // no room for another byte
    logic fill_zero;   // chunk empty
    logic store_fills; // the byte being stored completes the chunk
    logic idx_last;    // index points at the last stored byte
    logic out_free;    // result register can take a new result
  } dp_sts_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

  // Split a byte into four 2-bit groups, MSB first, each with the clock bit set.
  function automatic logic [4*SYM_W-1:0] groups8(input logic [7:0] v);
    return {1'b1, v[7:6], 1'b1, v[5:4], 1'b1, v[3:2], 1'b1, v[1:0]};
  endfunction

endpackage

[sv/fts_ctrl.sv]
// Controller: request decode, response bookkeeping and frame sequencing.
module fts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      command_i,
  input  logic            last_byte_i,
  input  logic            partner_error_i,
  input  fts_pkg::dp_sts_t sts_i,
  output fts_pkg::dp_cmd_t cmd_o
);
  import fts_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LAST   = 9'b000000010,
    S_START  = 9'b000000100,
    S_DATA   = 9'b000001000,
    S_CSMARK = 9'b000010000,
    S_CS     = 9'b000100000,
    S_END    = 9'b001000000,
    S_FIN1   = 9'b010000000,
    S_FIN2   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   await_q, await_d;
  logic   final_q, final_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    await_d = await_q;
    final_d = final_q;
    cmd_o   = '{store: 1'b0, clear: 1'b0, idx_inc: 1'b0, idx_clr: 1'b0,
                emit: 1'b0, kind: KIND_END, run_end: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_DATA: begin
              if (!await_q && !sts_i.fill_full) begin
                cmd_o.store = 1'b1;
                if (sts_i.store_fills || last_byte_i) begin
                  await_d = 1'b1;
                  if (last_byte_i) begin
                    final_d = 1'b1;
                    state_d = S_LAST;
                  end else begin
                    state_d = S_START;
                  end
                end
              end
            end
            CMD_RESP: begin
              if (await_q) begin
                if (partner_error_i) begin
                  state_d = S_START;
                end else begin
                  await_d     = 1'b0;
                  cmd_o.clear = 1'b1;
                  if (final_q) begin
                    final_d = 1'b0;
                    state_d = S_FIN1;
                  end
                end
              end
            end
            CMD_END: begin
              if (!await_q && sts_i.fill_zero) begin
                state_d = S_FIN1;
              end
            end
            default: begin
              // Drop unknown commands.
            end
          endcase
        end
      end
      S_LAST: begin
        cmd_o.kind = KIND_LAST;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.kind = KIND_START;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_DATA;
        end
      end
      S_DATA: begin
        cmd_o.kind = KIND_DATA;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_CSMARK;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_CSMARK: begin
        cmd_o.kind = KIND_CSMARK;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_CS;
        end
      end
      S_CS: begin
        cmd_o.kind = KIND_CS;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_END;
        end
      end
      S_END: begin
        cmd_o.kind    = KIND_END;
        cmd_o.run_end = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FIN1: begin
        cmd_o.kind = KIND_END;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_FIN2;
        end
      end
      S_FIN2: begin
        cmd_o.kind    = KIND_END;
        cmd_o.run_end = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      await_q <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      await_q <= await_d;
      final_q <= final_d;
    end
  end

endmodule

[sv/fts_dp.sv]
// Datapath: chunk memory, fill count, checksum and result register.
module fts_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_byte_i,
  input  fts_pkg::dp_cmd_t cmd_i,
  output fts_pkg::dp_sts_t sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       unit_kind_o,
  output logic [2:0]       symbol_count_o,
  output logic [2:0]       symbol_first_o,
  output logic [2:0]       symbol_second_o,
  output logic [2:0]       symbol_third_o,
  output logic [2:0]       symbol_fourth_o,
  output logic             run_end_o
);
  import fts_pkg::*;

  logic [7:0]        chunk_mem_q [CHUNK_BYTES];
  logic [7:0]        rd_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [4*SYM_W-1:0] sym_q, sym_d;
  logic              run_end_q;

  assign sts_o.fill_full   = (fill_q >= FILL_W'(CHUNK_BYTES));
  assign sts_o.fill_zero   = (fill_q == '0);
  assign sts_o.store_fills = ((fill_q + FILL_W'(1)) >= FILL_W'(CHUNK_BYTES));
  assign sts_o.idx_last    = (fill_q == (FILL_W'(idx_q) + FILL_W'(1)));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    fill_d = fill_q;
    sum_d  = sum_q;
    if (cmd_i.clear) begin
      fill_d = '0;
      sum_d  = '0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + FILL_W'(1);
      sum_d  = sum_q + SUM_W'(popcount8(data_byte_i));
    end
  end

  // Read address follows the next index so rd_q tracks the current byte.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      chunk_mem_q[fill_q[IDX_W-1:0]] <= data_byte_i;
    end
    rd_q <= chunk_mem_q[idx_d];
  end

  always_comb begin
    cnt_d = CNT_MARK;
    sym_d = '0;
    unique case (cmd_i.kind)
      KIND_LAST:   sym_d[4*SYM_W-1 -: SYM_W] = SYM_MARK_LAST;
      KIND_START:  sym_d[4*SYM_W-1 -: SYM_W] = SYM_MARK_START;
      KIND_CSMARK: sym_d[4*SYM_W-1 -: SYM_W] = SYM_MARK_CS;
      KIND_DATA: begin
        cnt_d = CNT_GROUPS;
        sym_d = groups8(rd_q);
      end
      KIND_CS: begin
        cnt_d = CNT_GROUPS;
        sym_d = groups8(sum_q);
      end
      default:     sym_d[4*SYM_W-1 -: SYM_W] = SYM_MARK_END;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      idx_q  <= idx_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q    <= cmd_i.kind;
      cnt_q     <= cnt_d;
      sym_q     <= sym_d;
      run_end_q <= cmd_i.run_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign unit_kind_o     = kind_q;
  assign symbol_count_o  = cnt_q;
  assign symbol_first_o  = sym_q[4*SYM_W-1 -: SYM_W];
  assign symbol_second_o = sym_q[3*SYM_W-1 -: SYM_W];
  assign symbol_third_o  = sym_q[2*SYM_W-1 -: SYM_W];
  assign symbol_fourth_o = sym_q[SYM_W-1 -: SYM_W];
  assign run_end_o       = run_end_q;

endmodule

[sv/framed_two_bit_symbol_sender_core.sv]
// Top level of the framed two-bit symbol sender: controller plus datapath.
//
// Requests carry a command: a data byte, a partner response or an end of an
// empty stream. Data bytes are stored in a 16-entry chunk memory, one per
// cycle, and give no result until the chunk fills or a byte is flagged last.
// Then the block sends a frame, one result per cycle while the output is not
// stalled: an optional last-block marker, the start marker, one four-symbol
// result per stored byte, the checksum marker, the checksum (sum of the
// bytes' popcounts) and the end marker, so a frame of n bytes holds n + 4 or
// n + 5 results, up to 21 for a full chunk. An error response replays the
// frame from memory without the last-block marker; an OK response empties
// the chunk and, after the final chunk, emits two end markers, as does an
// end command on an empty idle block. A request that causes no result keeps
// in_stall_o low. While a frame or end pair is being emitted, in_stall_o is
// high; the sequencer walking the chunk memory one byte per result sets the
// pace. run_end_o flags the last result caused by a request. Requests that
// do not fit the current state (data while a response is pending, a response
// with none pending, an end command with bytes held, unknown commands) are
// dropped silently. Symbols beyond symbol_count_o read as zero.
module framed_two_bit_symbol_sender_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       partner_error_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] unit_kind_o,
  output logic [2:0] symbol_count_o,
  output logic [2:0] symbol_first_o,
  output logic [2:0] symbol_second_o,
  output logic [2:0] symbol_third_o,
  output logic [2:0] symbol_fourth_o,
  output logic       run_end_o
);
  import fts_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Decode requests and sequence the frame.
  fts_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .last_byte_i,
    .partner_error_i,
    .sts_i (dp_sts),
    .cmd_o (dp_cmd)
  );

  // Hold the chunk, checksum and result register.
  fts_dp u_dp (
    .clk_i,
    .rst_ni,
    .data_byte_i,
    .cmd_i (dp_cmd),
    .sts_o (dp_sts),
    .out_valid_o,
    .out_stall_i,
    .unit_kind_o,
    .symbol_count_o,
    .symbol_first_o,
    .symbol_second_o,
    .symbol_third_o,
    .symbol_fourth_o,
    .run_end_o
  );

endmodule

[sv/fts_chk.sv]
// Port checker for the framed two-bit symbol sender, with its bind.
module fts_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] command_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] unit_kind_o,
  input logic [2:0] symbol_count_o,
  input logic [2:0] symbol_first_o,
  input logic [2:0] symbol_second_o,
  input logic [2:0] symbol_third_o,
  input logic [2:0] symbol_fourth_o,
  input logic       run_end_o
);
  import fts_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(unit_kind_o)
      && $stable(symbol_first_o) && $stable(symbol_fourth_o) && $stable(run_end_o))
    else $error("stalled result changed");

  // Data results carry four clocked symbols.
  a_data_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unit_kind_o == KIND_DATA |-> symbol_count_o == CNT_GROUPS
      && symbol_first_o[2] && symbol_second_o[2] && symbol_third_o[2] && symbol_fourth_o[2])
    else $error("malformed data result");

  // Every run closes on an end marker.
  a_run_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_end_o |-> unit_kind_o == KIND_END && symbol_first_o == SYM_MARK_END)
    else $error("run ended on a non-end unit");

  // An unknown command is dropped and leaves the block ready.
  a_unknown_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i != CMD_DATA && command_i != CMD_RESP
      && command_i != CMD_END |=> !in_stall_o)
    else $error("unknown command started work");

endmodule

bind framed_two_bit_symbol_sender_core fts_chk u_fts_chk (.*);

[verif/framed_two_bit_symbol_sender_core_tb.sv]
// Self-checking testbench of the framed two-bit symbol sender core.
`timescale 1ns / 100ps

module framed_two_bit_symbol_sender_core_tb;
  import fts_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_REQS = 380;

  // The command field has one code the block does not know; it must be dropped.
  localparam logic [1:0]       CMD_UNKNOWN = 2'd3;
  localparam logic [SYM_W-1:0] CLOCK_BIT   = 3'd4;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       last;
    logic       err;
    bit         pause;  // hold this request back until every unit has come out
  } request_t;

  typedef struct packed {
    kind_e            kind;
    logic [CNT_W-1:0] cnt;
    logic [SYM_W-1:0] s1;
    logic [SYM_W-1:0] s2;
    logic [SYM_W-1:0] s3;
    logic [SYM_W-1:0] s4;
    logic             run_end;
  } unit_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [1:0] command_i       = CMD_DATA;
  logic [7:0] data_byte_i     = 8'd0;
  logic       last_byte_i     = 1'b0;
  logic       partner_error_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [2:0] unit_kind_o;
  logic [2:0] symbol_count_o;
  logic [2:0] symbol_first_o;
  logic [2:0] symbol_second_o;
  logic [2:0] symbol_third_o;
  logic [2:0] symbol_fourth_o;
  logic       run_end_o;

  framed_two_bit_symbol_sender_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .partner_error_i(partner_error_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .unit_kind_o    (unit_kind_o),
    .symbol_count_o (symbol_count_o),
    .symbol_first_o (symbol_first_o),
    .symbol_second_o(symbol_second_o),
    .symbol_third_o (symbol_third_o),
    .symbol_fourth_o(symbol_fourth_o),
    .run_end_o      (run_end_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Request stream waiting for the driver, and the symbol units still owed.
  request_t queued_requests[$];
  unit_t    awaited_units[$];

  // Shadow of the sender: chunk memory, fill level, response and final flags,
  // and the running popcount sum that becomes the checksum.
  logic [7:0]       held_bytes[CHUNK_BYTES];
  int unsigned      held_count    = 0;
  bit               resp_pending  = 1'b0;
  bit               final_pending = 1'b0;
  logic [SUM_W-1:0] ones_total    = '0;

  int unsigned reqs_total    = 0;
  int unsigned reqs_accepted = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  bit          req_fired       = 1'b0;
  request_t    next_req;
  unit_t       want;

  // Stimulus generator bookkeeping.
  int unsigned gen_fill    = 0;
  bit          pause_next  = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void add_unit(kind_e k, logic [CNT_W-1:0] cnt, logic [SYM_W-1:0] a,
                                   logic [SYM_W-1:0] b, logic [SYM_W-1:0] c,
                                   logic [SYM_W-1:0] d);
    unit_t u;
    u.kind    = k;
    u.cnt     = cnt;
    u.s1      = a;
    u.s2      = b;
    u.s3      = c;
    u.s4      = d;
    u.run_end = 1'b0;
    awaited_units = {awaited_units, u};
  endfunction

  function automatic void add_mark(kind_e k, logic [SYM_W-1:0] sym);
    add_unit(k, CNT_MARK, sym, '0, '0, '0);
  endfunction

  // Four 2-bit groups, most significant first, each lifted by the clock bit.
  function automatic void add_groups(kind_e k, logic [7:0] v);
    add_unit(k, CNT_GROUPS, CLOCK_BIT + v[7:6], CLOCK_BIT + v[5:4],
             CLOCK_BIT + v[3:2], CLOCK_BIT + v[1:0]);
  endfunction

  function automatic void add_frame();
    add_mark(KIND_START, SYM_MARK_START);
    for (int unsigned i = 0; i < held_count; i++) begin
      add_groups(KIND_DATA, held_bytes[IDX_W'(i)]);
    end
    add_mark(KIND_CSMARK, SYM_MARK_CS);
    add_groups(KIND_CS, ones_total);
    add_mark(KIND_END, SYM_MARK_END);
  endfunction

  // Advance the shadow state by one accepted request and queue the units it
  // must produce; flag the last of them as the end of the run.
  function automatic void compute_units(logic [1:0] cmd, logic [7:0] data, logic last,
                                        logic err);
    int unsigned start_size;
    start_size = awaited_units.size();
    case (cmd)
      CMD_DATA: begin
        if (!resp_pending && held_count < CHUNK_BYTES) begin
          held_bytes[IDX_W'(held_count)] = data;
          held_count++;
          ones_total = ones_total + SUM_W'($countones(data));
          if (held_count == CHUNK_BYTES || last) begin
            if (last) begin
              final_pending = 1'b1;
              add_mark(KIND_LAST, SYM_MARK_LAST);
            end
            add_frame();
            resp_pending = 1'b1;
          end
        end
      end
      CMD_RESP: begin
        if (resp_pending) begin
          if (err) begin
            add_frame();
          end else begin
            resp_pending = 1'b0;
            held_count   = 0;
            ones_total   = '0;
            if (final_pending) begin
              final_pending = 1'b0;
              add_mark(KIND_END, SYM_MARK_END);
              add_mark(KIND_END, SYM_MARK_END);
            end
          end
        end
      end
      CMD_END: begin
        if (!resp_pending && held_count == 0) begin
          add_mark(KIND_END, SYM_MARK_END);
          add_mark(KIND_END, SYM_MARK_END);
        end
      end
      default: ;
    endcase
    if (awaited_units.size() > start_size) begin
      awaited_units[awaited_units.size() - 1].run_end = 1'b1;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic queue_req(input logic [1:0] cmd, input logic [7:0] data, input logic last,
                           input logic err);
    request_t r;
    r.cmd   = cmd;
    r.data  = data;
    r.last  = last;
    r.err   = err;
    r.pause = pause_next;
    pause_next = 1'b0;
    queued_requests = {queued_requests, r};
  endtask

  // Answer a frame: up to two error responses (each replays the frame), sometimes
  // with dropped noise in between, then the accepting response.
  task automatic answer_frame();
    int unsigned n_err;
    n_err = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    for (int unsigned k = 0; k < n_err; k++) begin
      case ($urandom_range(9))
        0: queue_req(CMD_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
        1: queue_req(CMD_END, 8'($urandom), 1'($urandom), 1'($urandom));
        default: ;
      endcase
      queue_req(CMD_RESP, 8'($urandom), 1'($urandom), 1'b1);
    end
    if ($urandom_range(9) == 0) begin
      queue_req(CMD_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    queue_req(CMD_RESP, 8'($urandom), 1'($urandom), 1'b0);
  endtask

  // Send a stream of bytes, answering each frame as it goes out. Without the
  // last flag the tail stays in the chunk and the next stream tops it up.
  task automatic gen_stream(input int unsigned nbytes, input bit flag_last);
    logic lst;
    for (int unsigned i = 0; i < nbytes; i++) begin
      lst = flag_last && (i == nbytes - 1);
      if (gen_fill > 0 && $urandom_range(19) == 0) begin
        queue_req(CMD_END, 8'($urandom), 1'($urandom), 1'($urandom));
      end
      queue_req(CMD_DATA, 8'($urandom), lst, 1'($urandom));
      gen_fill++;
      if (gen_fill == CHUNK_BYTES || lst) begin
        gen_fill = 0;
        answer_frame();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one request at a time, hold it until it is taken
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !req_fired) begin
      // Hold the stalled request as it is.
    end else if (queued_requests.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (queued_requests[0].pause && awaited_units.size() != 0) begin
      // Wait for the block to drain before this request goes out.
      in_valid_i <= 1'b0;
    end else if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
    end else begin
      next_req = queued_requests.pop_front();
      command_i       <= next_req.cmd;
      data_byte_i     <= next_req.data;
      last_byte_i     <= next_req.last;
      partner_error_i <= next_req.err;
      in_valid_i      <= 1'b1;
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, predict from accepted requests, pick the phase
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    req_fired <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_units.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d count %0d run_end %0d",
                 $time, unit_kind_o, symbol_count_o, run_end_o);
        mismatch_cnt++;
      end else begin
        want = awaited_units.pop_front();
        check_field("unit_kind", want.kind, unit_kind_o);
        check_field("symbol_count", want.cnt, symbol_count_o);
        check_field("symbol_first", want.s1, symbol_first_o);
        check_field("symbol_second", want.s2, symbol_second_o);
        check_field("symbol_third", want.s3, symbol_third_o);
        check_field("symbol_fourth", want.s4, symbol_fourth_o);
        check_field("run_end", want.run_end, run_end_o);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      compute_units(command_i, data_byte_i, last_byte_i, partner_error_i);
      reqs_accepted++;
      // Advance through the idling phases as the run progresses.
      case ((reqs_accepted * 5) / reqs_total)
        1: begin sender_idle_pct = 81; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 81; end
        3: begin sender_idle_pct = 15; stall_pct = 15; end
        default: begin sender_idle_pct = 0; stall_pct = 0; end
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** framed_two_bit_symbol_sender_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    // Directed: end pair on an empty block, dropped requests of every kind,
    // extreme bytes, a final chunk with its last-block marker, a replay and
    // the closing end pair, then a full chunk without the last flag.
    queue_req(CMD_END, 8'h00, 1'b0, 1'b0);
    queue_req(CMD_RESP, 8'h00, 1'b0, 1'b1);
    queue_req(CMD_UNKNOWN, 8'hFF, 1'b1, 1'b1);
    queue_req(CMD_DATA, 8'h00, 1'b0, 1'b0);
    queue_req(CMD_END, 8'hFF, 1'b1, 1'b1);
    queue_req(CMD_DATA, 8'hFF, 1'b1, 1'b1);
    queue_req(CMD_DATA, 8'hA5, 1'b1, 1'b0);
    queue_req(CMD_END, 8'h00, 1'b0, 1'b0);
    queue_req(CMD_RESP, 8'h00, 1'b0, 1'b1);
    queue_req(CMD_RESP, 8'hFF, 1'b1, 1'b0);
    for (int unsigned i = 0; i < CHUNK_BYTES; i++) begin
      queue_req(CMD_DATA, {i[3:0], ~i[3:0]}, 1'b0, i[0]);
    end
    pause_next = 1'b1;
    queue_req(CMD_RESP, 8'h5A, 1'b0, 1'b0);

    // Random: mostly well-formed streams, some bare end commands and noise.
    while (queued_requests.size() < RANDOM_REQS) begin
      case ($urandom_range(99)) inside
        [0:79]: begin
          if ($urandom_range(7) == 0) begin
            gen_stream($urandom_range(17, 40), $urandom_range(9) != 0);
          end else begin
            gen_stream($urandom_range(1, CHUNK_BYTES), $urandom_range(9) != 0);
          end
        end
        [80:87]: begin
          queue_req(CMD_END, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        default: begin
          if ($urandom_range(1) == 0) begin
            queue_req(CMD_RESP, 8'($urandom), 1'($urandom), 1'($urandom));
          end else begin
            queue_req(CMD_UNKNOWN, 8'($urandom), 1'($urandom), 1'($urandom));
          end
        end
      endcase
      if ($urandom_range(24) == 0) begin
        pause_next = 1'b1;
      end
    end
    reqs_total = queued_requests.size();

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every request to be taken and every unit to come out.
    while (reqs_accepted != reqs_total || awaited_units.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("** framed_two_bit_symbol_sender_core: PASSED **");
    end else begin
      $display("** framed_two_bit_symbol_sender_core: FAILED **");
    end
    $finish;
  end

endmodule
